[hdl/atte_pkg.sv]
// Package with shared constants, types and a helper function of the text terminal engine.
package atte_pkg;

	localparam int unsigned COLS_DEF     = 80;
	localparam int unsigned ROWS_DEF     = 25;
	localparam int unsigned MAX_ARGS_DEF = 16;

	localparam int unsigned CELL_W  = 11;
	localparam int unsigned COL_W   = 7;
	localparam int unsigned ROW_W   = 5;
	localparam int unsigned LINES_W = 5;
	localparam int unsigned PVAL_W  = 16;

	localparam logic [PVAL_W-1:0] SAT_MAX = 16'hFFFF;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] ATTR_FG_KEEP = 8'hF8;
	localparam logic [7:0] ATTR_BG_KEEP = 8'h0F;
	localparam logic [7:0] ATTR_BRIGHT = 8'h08;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_J    = 8'h4A;
	localparam logic [7:0] CH_K    = 8'h4B;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_LC_C = 8'h63;
	localparam logic [7:0] CH_LC_D = 8'h64;
	localparam logic [7:0] CH_LC_F = 8'h66;
	localparam logic [7:0] CH_LC_M = 8'h6D;
	localparam logic [7:0] CH_LC_S = 8'h73;
	localparam logic [7:0] CH_LC_U = 8'h75;

	typedef enum logic [2:0] {
		CMD_CURSOR = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_FILL   = 3'd2,
		CMD_SCR_UP = 3'd3,
		CMD_SCR_DN = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic byte_load;   // decode the captured byte, load its results
		logic sgr_step;    // apply one stored parameter to the attribute
		logic sgr_clear;   // start the parameter walk
		logic res_pop;     // second result was taken
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_sgr;      // decoded byte is a CSI m final
		logic two_res;     // byte gives two results
		logic sgr_done;    // last parameter slot reached
	} dp_sts_t;

	// Color table for SGR 30..37, also used for the backgrounds 40..47.
	function automatic logic [2:0] fg_color(input logic [2:0] idx);
		logic [2:0] r;
		case (idx)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

endpackage

[hdl/atte_if.sv]
// Valid/ready channel interfaces for input bytes and result requests.
interface atte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface atte_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [10:0] start_cell;
	logic [10:0] end_cell;
	logic [7:0]  glyph;
	logic [7:0]  attr;
	logic [4:0]  scroll_lines;
	logic [6:0]  cur_col;
	logic [4:0]  cur_row;
	logic        last;
	modport source (output valid, output cmd, output start_cell, output end_cell,
		output glyph, output attr, output scroll_lines, output cur_col, output cur_row,
		output last, input ready);
	modport sink (input valid, input cmd, input start_cell, input end_cell,
		input glyph, input attr, input scroll_lines, input cur_col, input cur_row,
		input last, output ready);
endinterface

[hdl/ansi_text_terminal_engine.sv]
// Top level of the ANSI escape-sequence text terminal engine.
// Usage:
// The input channel takes one byte of the character stream per request.
// The output channel gives one or two result requests per byte: a cell
// write, a blank fill, a scroll or a cursor-only report, each with the
// cursor position after the byte; last marks the final result.
// One byte is worked on at a time. A byte is taken in the idle state,
// decoded in the decode state, and its first result is then shown.
// A byte that ends an SGR (m) sequence first walks all MAX_ARGS stored
// parameters, one per cycle, before its result.
// A byte with two results shows its second result after the first is taken.
// The input is not ready again until the last result of a byte has been
// taken; when the receiver stalls, the result is held steady.
// Reset puts the parser in normal mode, the cursor and saved cursor at the
// top left corner, clears all parameters and sets the attribute to gray on
// black. No screen clearing request is issued at reset.
module ansi_text_terminal_engine #(
	parameter int unsigned COLS     = atte_pkg::COLS_DEF,
	parameter int unsigned ROWS     = atte_pkg::ROWS_DEF,
	parameter int unsigned MAX_ARGS = atte_pkg::MAX_ARGS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	atte_in_if.sink    in_ch,
	atte_out_if.source out_ch
);
	import atte_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;
	logic    second;

	// The controller owns the handshakes; the datapath holds the parser, cursor, attribute and result state.
	atte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_second(second), .cmd(dcmd), .sts(dsts)
	);

	atte_dp #(.COLS(COLS), .ROWS(ROWS), .MAX_ARGS(MAX_ARGS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_take(in_ch.valid && in_ch.ready), .in_byte(in_ch.in_byte),
		.out_second(second), .cmd(dcmd), .sts(dsts),
		.o_cmd(out_ch.cmd), .o_start(out_ch.start_cell), .o_end(out_ch.end_cell),
		.o_glyph(out_ch.glyph), .o_attr(out_ch.attr), .o_lines(out_ch.scroll_lines),
		.o_col(out_ch.cur_col), .o_row(out_ch.cur_row), .o_last(out_ch.last)
	);
endmodule

[hdl/atte_ctrl.sv]
// Controller state machine sequencing byte decode, SGR walk and result output.
module atte_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_second,
	output atte_pkg::dp_cmd_t   cmd,
	input  atte_pkg::dp_sts_t   sts
);
	import atte_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DEC   = 5'b00010,
		ST_SGR   = 5'b00100,
		ST_OUT1  = 5'b01000,
		ST_OUT2  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_second = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.byte_load = 1'b1;
				if (sts.is_sgr) begin
					cmd.sgr_clear = 1'b1;
					state_d = ST_SGR;
				end else begin
					state_d = ST_OUT1;
				end
			end
			ST_SGR: begin
				cmd.sgr_step = 1'b1;
				if (sts.sgr_done) state_d = ST_OUT1;
			end
			ST_OUT1: begin
				out_valid = 1'b1;
				if (out_ready) state_d = sts.two_res ? ST_OUT2 : ST_IDLE;
			end
			ST_OUT2: begin
				out_valid = 1'b1;
				out_second = 1'b1;
				if (out_ready) begin
					cmd.res_pop = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("accept while output pending");
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT2) |-> $past(out_valid)) else $error("second without first");
	a_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DEC)) else $error("no decode");
endmodule

[hdl/atte_dp.sv]
// Datapath: parser state, parameters, cursor, attribute and result registers.
module atte_dp #(
	parameter int unsigned COLS     = atte_pkg::COLS_DEF,
	parameter int unsigned ROWS     = atte_pkg::ROWS_DEF,
	parameter int unsigned MAX_ARGS = atte_pkg::MAX_ARGS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_take,
	input  logic [7:0]                        in_byte,
	input  logic                              out_second,
	input  atte_pkg::dp_cmd_t                 cmd,
	output atte_pkg::dp_sts_t                 sts,
	output logic [2:0]                        o_cmd,
	output logic [atte_pkg::CELL_W-1:0]       o_start,
	output logic [atte_pkg::CELL_W-1:0]       o_end,
	output logic [7:0]                        o_glyph,
	output logic [7:0]                        o_attr,
	output logic [atte_pkg::LINES_W-1:0]      o_lines,
	output logic [atte_pkg::COL_W-1:0]        o_col,
	output logic [atte_pkg::ROW_W-1:0]        o_row,
	output logic                              o_last
);
	import atte_pkg::*;

	localparam int unsigned SLOT_W = $clog2(MAX_ARGS + 1);
	localparam int unsigned IDX_W  = $clog2(MAX_ARGS);
	localparam logic [COL_W-1:0] COLS_C = COL_W'(COLS);
	localparam logic [ROW_W-1:0] ROWS_C = ROW_W'(ROWS);
	localparam logic [CELL_W-1:0] SCREEN = CELL_W'(ROWS * COLS);

	typedef struct packed {
		cmd_t                 c;
		logic [CELL_W-1:0]    s;
		logic [CELL_W-1:0]    e;
		logic [7:0]           g;
		logic [7:0]           a;
		logic [LINES_W-1:0]   l;
	} res_t;

	logic [7:0]          byte_q;
	mode_t               mode_q;
	logic [PVAL_W-1:0]   pval_q [MAX_ARGS];
	logic [MAX_ARGS-1:0] pgiv_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COL_W-1:0]    col_q, scol_q;
	logic [ROW_W-1:0]    row_q, srow_q;
	logic [7:0]          attr_q;
	logic [IDX_W-1:0]    sgr_idx_q;
	res_t                r0_q, r1_q;
	logic                two_q;

	always_ff @(posedge clk) if (in_take) byte_q <= in_byte;

	// Byte decode, combinational over the current state.
	logic [PVAL_W-1:0] p0, p1, sel;
	logic [COL_W-1:0]  col_d, scol_d;
	logic [ROW_W-1:0]  row_d, srow_d;
	logic [7:0]        attr_d;
	mode_t             mode_d;
	res_t              ra, rb;
	logic              na, nb, clr_par, dig, is_sgr;
	logic [CELL_W-1:0] here, rowbase, fs, fe;
	logic              fv;
	logic [PVAL_W+3:0] dsum;
	logic [PVAL_W:0]   csum;
	logic [LINES_W-1:0] cnt;

	assign p0 = pgiv_q[0] ? pval_q[0] : PVAL_W'(1);
	assign p1 = pgiv_q[1] ? pval_q[1] : PVAL_W'(1);
	assign sel = pgiv_q[0] ? pval_q[0] : '0;
	assign here = CELL_W'(row_q) * CELL_W'(COLS) + CELL_W'(col_q);
	assign rowbase = CELL_W'(row_q) * CELL_W'(COLS);
	assign dsum = PVAL_W'(0) + pval_q[slot_q[IDX_W-1:0]] * 4'd10 + (byte_q - CH_0);
	assign csum = {1'b0, p0} + PVAL_W'(col_q);
	assign cnt = (p0 > PVAL_W'(ROWS)) ? LINES_W'(ROWS) : LINES_W'(p0);

	always_comb begin
		mode_d = mode_q; col_d = col_q; row_d = row_q; scol_d = scol_q;
		srow_d = srow_q; attr_d = attr_q;
		ra = '0; rb = '0; na = 1'b0; nb = 1'b0; clr_par = 1'b0; dig = 1'b0;
		is_sgr = 1'b0; fs = '0; fe = '0; fv = 1'b0;
		unique case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_NORMAL;
				if (byte_q == CH_LBR) begin
					mode_d = MODE_CSI;
					clr_par = 1'b1;
				end else if (byte_q == CH_LC_C) begin
					attr_d = ATTR_RESET;
					ra = '{CMD_FILL, '0, SCREEN, 8'd0, ATTR_RESET, '0};
					na = 1'b1;
					col_d = '0; row_d = '0; scol_d = '0; srow_d = '0;
				end
			end
			MODE_CSI: begin
				if (byte_q >= CH_0 && byte_q <= CH_9) begin
					dig = slot_q < SLOT_W'(MAX_ARGS);
				end else if (byte_q == CH_SEMI) begin
					if (slot_q + 1'b1 >= SLOT_W'(MAX_ARGS)) mode_d = MODE_NORMAL;
				end else begin
					mode_d = MODE_NORMAL;
					case (byte_q)
						CH_A, CH_F: begin
							row_d = (PVAL_W'(row_q) < p0) ? '0 : row_q - ROW_W'(p0);
							if (byte_q == CH_F) col_d = '0;
						end
						CH_B, CH_E: begin
							row_d = ({1'b0, p0} + PVAL_W'(row_q) >= (PVAL_W+1)'(ROWS))
								? ROWS_C - 1'b1 : row_q + ROW_W'(p0);
							if (byte_q == CH_E) col_d = '0;
						end
						CH_C: col_d = (csum >= (PVAL_W+1)'(COLS)) ? '0 : COL_W'(csum);
						CH_D: col_d = (PVAL_W'(col_q) < p0) ? '0 : col_q - COL_W'(p0);
						CH_G: if (p0 > 0 && p0 < PVAL_W'(COLS)) col_d = COL_W'(p0 - 1'b1);
						CH_H, CH_LC_F: begin
							if (p1 > 0 && p1 < PVAL_W'(COLS) && p0 > 0 && p0 < PVAL_W'(ROWS)) begin
								col_d = COL_W'(p1 - 1'b1);
								row_d = ROW_W'(p0 - 1'b1);
							end
						end
						CH_LC_D: if (p0 > 0 && p0 < PVAL_W'(ROWS)) row_d = ROW_W'(p0 - 1'b1);
						CH_J: begin
							fv = 1'b1;
							if (sel == 0) begin fs = here; fe = SCREEN; end
							else if (sel == 1) begin fs = '0; fe = here; end
							else if (sel == 2) begin fs = '0; fe = SCREEN; end
							else fv = 1'b0;
						end
						CH_K: begin
							fv = 1'b1;
							if (sel == 0) begin fs = here; fe = rowbase + CELL_W'(COLS); end
							else if (sel == 1) begin fs = rowbase; fe = here; end
							else if (sel == 2) begin fs = rowbase; fe = rowbase + CELL_W'(COLS); end
							else fv = 1'b0;
						end
						CH_S: begin ra = '{CMD_SCR_UP, '0, '0, 8'd0, attr_q, cnt}; na = 1'b1; end
						CH_T: begin ra = '{CMD_SCR_DN, '0, '0, 8'd0, attr_q, cnt}; na = 1'b1; end
						CH_LC_M: is_sgr = 1'b1;
						CH_LC_S: begin scol_d = col_q; srow_d = row_q; end
						CH_LC_U: begin col_d = scol_q; row_d = srow_q; end
						default: ;
					endcase
					if (fv && fs < fe) begin
						ra = '{CMD_FILL, fs, fe, 8'd0, attr_q, '0};
						na = 1'b1;
					end
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (byte_q == CH_ESC) mode_d = MODE_ESC;
				else begin
					if (byte_q == CH_LF || col_q > COLS_C - 1'b1) begin
						col_d = '0;
						row_d = row_q + 1'b1;
						if (row_q + 1'b1 > ROWS_C - 1'b1) begin
							ra = '{CMD_SCR_UP, '0, '0, 8'd0, attr_q, LINES_W'(1)};
							na = 1'b1;
							row_d = ROWS_C - 1'b1;
						end
					end
					if (byte_q != CH_LF) begin
						rb = '{CMD_WRITE, CELL_W'(row_d) * CELL_W'(COLS), '0, byte_q, attr_q, '0};
						rb.s = rb.s + CELL_W'(col_d);
						nb = 1'b1;
						col_d = col_d + 1'b1;
					end
				end
			end
		endcase
	end

	assign sts.is_sgr = is_sgr;
	assign sts.two_res = two_q;
	assign sts.sgr_done = (sgr_idx_q == IDX_W'(MAX_ARGS - 1));

	// SGR: one stored parameter per cycle.
	logic [PVAL_W-1:0] v;
	logic [7:0] sgr_attr;
	assign v = pval_q[sgr_idx_q];
	always_comb begin
		sgr_attr = attr_q;
		if (pgiv_q[sgr_idx_q]) begin
			if (v == 0) sgr_attr = ATTR_RESET;
			else if (v == 1) sgr_attr = attr_q | ATTR_BRIGHT;
			else if (v == 22) sgr_attr = attr_q & ~ATTR_BRIGHT;
			else if (v >= 30 && v <= 37) sgr_attr = (attr_q & ATTR_FG_KEEP) | {5'd0, fg_color(v[2:0] - 3'd6)};
			else if (v == 39) sgr_attr = (attr_q & ATTR_FG_KEEP) | ATTR_RESET;
			else if (v >= 40 && v <= 47) sgr_attr = (attr_q & ATTR_BG_KEEP) | {1'b0, fg_color(v[2:0]), 4'd0};
			else if (v == 49) sgr_attr = attr_q & ATTR_BG_KEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL; pgiv_q <= '0; slot_q <= '0; col_q <= '0; row_q <= '0;
			scol_q <= '0; srow_q <= '0; attr_q <= ATTR_RESET; sgr_idx_q <= '0; two_q <= 1'b0;
			r0_q <= '0; r1_q <= '0;
			for (int i = 0; i < MAX_ARGS; i++) pval_q[i] <= '0;
		end else begin
			if (cmd.byte_load) begin
				mode_q <= mode_d; col_q <= col_d; row_q <= row_d;
				scol_q <= scol_d; srow_q <= srow_d; attr_q <= attr_d;
				two_q <= na && nb;
				r0_q <= na ? ra : (nb ? rb : res_t'('0));
				r1_q <= rb;
				if (clr_par) begin
					pgiv_q <= '0; slot_q <= '0;
					for (int i = 0; i < MAX_ARGS; i++) pval_q[i] <= '0;
				end
				if (mode_q == MODE_CSI && byte_q == CH_SEMI) slot_q <= slot_q + 1'b1;
				if (dig) begin
					pval_q[slot_q[IDX_W-1:0]] <= (dsum > PVAL_W'(SAT_MAX)) ? SAT_MAX : PVAL_W'(dsum);
					pgiv_q[slot_q[IDX_W-1:0]] <= 1'b1;
				end
			end
			if (cmd.sgr_clear) sgr_idx_q <= '0;
			if (cmd.sgr_step) begin
				attr_q <= sgr_attr;
				sgr_idx_q <= sgr_idx_q + 1'b1;
			end
			if (cmd.res_pop) two_q <= 1'b0;
		end
	end

	always_comb begin
		res_t r;
		r = out_second ? r1_q : r0_q;
		o_cmd = r.c; o_start = r.s; o_end = r.e; o_glyph = r.g; o_attr = r.a; o_lines = r.l;
		o_col = col_q; o_row = row_q;
		o_last = out_second || !two_q;
	end

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(MAX_ARGS)) else $error("slot overflow");
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COLS_C) else $error("column out of range");
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < ROWS_C) else $error("row out of range");
endmodule

[verif/atte_tb_if.sv]
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces come from the RTL; this file holds the result record type.
package atte_tb_pkg;
	import atte_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [10:0] start_cell;
		logic [10:0] end_cell;
		logic [7:0]  glyph;
		logic [7:0]  attr;
		logic [4:0]  scroll_lines;
		logic [6:0]  cur_col;
		logic [4:0]  cur_row;
		logic        last;
	} screen_op_t;
endpackage

[verif/tb_ansi_text_terminal_engine.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the text terminal engine with a built-in terminal predictor.
module tb_ansi_text_terminal_engine;
	import atte_pkg::*;
	import atte_tb_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int NARGS = 16;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors;

	atte_in_if  in_ch ();
	atte_out_if out_ch ();

	ansi_text_terminal_engine dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Predictor state: a shadow of the terminal's parser, cursor and attribute.
	mode_t       term_mode;
	logic [15:0] arg_val [NARGS];
	logic        arg_set [NARGS];
	int          arg_idx;
	int          col, row, save_col, save_row;
	logic [7:0]  cur_attr;

	// Expected screen operations, oldest first.
	screen_op_t  pending_ops[$];
	// Results of the byte being predicted, before the cursor is stamped.
	screen_op_t  step_ops[$];

	int  burst_left;
	bit  sender_idle_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic void push_op(input cmd_t c, input int s, input int e, input int g,
		input int lines);
		screen_op_t op;
		op = '0;
		op.cmd = c;
		op.start_cell = s[10:0];
		op.end_cell = e[10:0];
		op.glyph = g[7:0];
		op.attr = (c == CMD_CURSOR) ? 8'h00 : cur_attr;
		op.scroll_lines = lines[4:0];
		step_ops.push_back(op);
	endfunction

	function automatic void push_fill(input int s, input int e);
		if (s < e) push_op(CMD_FILL, s, e, 0, 0);
	endfunction

	function automatic int param_or(input int i, input int dflt);
		return arg_set[i] ? int'(arg_val[i]) : dflt;
	endfunction

	function automatic void apply_colors();
		int v;
		for (int i = 0; i < NARGS; i++) begin
			if (arg_set[i]) begin
				v = arg_val[i];
				if (v == 0) cur_attr = ATTR_RESET;
				else if (v == 1) cur_attr = cur_attr | ATTR_BRIGHT;
				else if (v == 22) cur_attr = cur_attr & ~ATTR_BRIGHT;
				else if (v >= 30 && v <= 37) begin
					// ANSI color order differs from the adapter's RGB bit order.
					case (v - 30)
						0: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd0;
						1: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd4;
						2: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd2;
						3: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd6;
						4: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd1;
						5: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd5;
						6: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd3;
						default: cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'd7;
					endcase
				end else if (v == 39) cur_attr = (cur_attr & ATTR_FG_KEEP) | 8'h07;
				else if (v == 49) cur_attr = cur_attr & ATTR_BG_KEEP;
				else if (v >= 40 && v <= 47) begin
					case (v - 40)
						0: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h00;
						1: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h40;
						2: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h20;
						3: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h60;
						4: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h10;
						5: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h50;
						6: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h30;
						default: cur_attr = (cur_attr & ATTR_BG_KEEP) | 8'h70;
					endcase
				end
			end
		end
	endfunction

	// Prints a character, or advances a line for a line feed. A pending wrap
	// (column == COLS) is resolved first, scrolling up past the bottom row.
	function automatic void put_char(input logic [7:0] c);
		if (c == CH_LF || col > COLS - 1) begin
			col = 0;
			row++;
			if (row > ROWS - 1) begin
				push_op(CMD_SCR_UP, 0, 0, 0, 1);
				row = ROWS - 1;
			end
			if (c == CH_LF) return;
		end
		push_op(CMD_WRITE, row * COLS + col, 0, c, 0);
		col++;
	endfunction

	function automatic void run_command(input logic [7:0] c);
		int p, x, here, sel;
		p = param_or(0, 1);
		here = row * COLS + col;
		case (c)
			CH_A, CH_F: begin
				row = (row < p) ? 0 : row - p;
				if (c == CH_F) col = 0;
			end
			CH_B, CH_E: begin
				row = (row + p >= ROWS) ? ROWS - 1 : row + p;
				if (c == CH_E) col = 0;
			end
			CH_C: col = (col + p >= COLS) ? 0 : col + p;
			CH_D: col = (col < p) ? 0 : col - p;
			CH_G: if (p > 0 && p < COLS) col = p - 1;
			CH_H, CH_LC_F: begin
				x = param_or(1, 1);
				if (x > 0 && x < COLS && p > 0 && p < ROWS) begin
					col = x - 1;
					row = p - 1;
				end
			end
			CH_LC_D: if (p > 0 && p < ROWS) row = p - 1;
			CH_J: begin
				sel = param_or(0, 0);
				if (sel == 0) push_fill(here, ROWS * COLS);
				else if (sel == 1) push_fill(0, here);
				else if (sel == 2) push_fill(0, ROWS * COLS);
			end
			CH_K: begin
				sel = param_or(0, 0);
				if (sel == 0) push_fill(here, (row + 1) * COLS);
				else if (sel == 1) push_fill(row * COLS, here);
				else if (sel == 2) push_fill(row * COLS, (row + 1) * COLS);
			end
			CH_S, CH_T: begin
				if (p > ROWS) p = ROWS;
				push_op((c == CH_S) ? CMD_SCR_UP : CMD_SCR_DN, 0, 0, 0, p);
			end
			CH_LC_M: apply_colors();
			CH_LC_S: begin
				save_col = col;
				save_row = row;
			end
			CH_LC_U: begin
				col = save_col;
				row = save_row;
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_byte(input logic [7:0] c);
		int v;
		screen_op_t op;
		step_ops.delete();
		if (term_mode == MODE_ESC) begin
			term_mode = MODE_NORMAL;
			if (c == CH_LBR) begin
				term_mode = MODE_CSI;
				for (int i = 0; i < NARGS; i++) begin
					arg_val[i] = '0;
					arg_set[i] = 1'b0;
				end
				arg_idx = 0;
			end else if (c == CH_LC_C) begin
				cur_attr = ATTR_RESET;
				push_op(CMD_FILL, 0, ROWS * COLS, 0, 0);
				col = 0; row = 0; save_col = 0; save_row = 0;
			end
		end else if (term_mode == MODE_CSI) begin
			if (c >= CH_0 && c <= CH_9) begin
				if (arg_idx < NARGS) begin
					v = int'(arg_val[arg_idx]) * 10 + int'(c - CH_0);
					arg_val[arg_idx] = (v > 65535) ? SAT_MAX : v[15:0];
					arg_set[arg_idx] = 1'b1;
				end
			end else if (c == CH_SEMI) begin
				arg_idx++;
				if (arg_idx >= NARGS) term_mode = MODE_NORMAL;
			end else begin
				run_command(c);
				term_mode = MODE_NORMAL;
			end
		end else if (c == CH_ESC) begin
			term_mode = MODE_ESC;
		end else begin
			put_char(c);
		end
		if (step_ops.size() == 0) push_op(CMD_CURSOR, 0, 0, 0, 0);
		foreach (step_ops[k]) begin
			op = step_ops[k];
			op.cur_col = col[6:0];
			op.cur_row = row[4:0];
			op.last = (k == step_ops.size() - 1);
			pending_ops.push_back(op);
		end
	endfunction

	// Sends one byte; with idle gaps enabled, the sender pauses between bursts of random length.
	// Valid stays high across back-to-back requests and drops only in a gap.
	task automatic send_byte(input logic [7:0] b);
		if (sender_idle_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		if (burst_left > 0) burst_left--;
		predict_byte(b);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// Receiver stall pattern: stretches of always-ready alternate with
	// stretches of random back-pressure.
	initial begin
		int phase;
		out_ch.ready = 1'b0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase = (phase + 1) % 200;
			if (phase < 60) out_ch.ready <= 1'b1;
			else if (phase < 140) out_ch.ready <= ($urandom_range(0, 3) != 0);
			else out_ch.ready <= ($urandom_range(0, 1) != 0);
		end
	end

	// Result checker: compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		screen_op_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.cmd = cmd_t'(out_ch.cmd);
			got.start_cell = out_ch.start_cell;
			got.end_cell = out_ch.end_cell;
			got.glyph = out_ch.glyph;
			got.attr = out_ch.attr;
			got.scroll_lines = out_ch.scroll_lines;
			got.cur_col = out_ch.cur_col;
			got.cur_row = out_ch.cur_row;
			got.last = out_ch.last;
			if (pending_ops.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = pending_ops.pop_front();
				if (got.cmd !== want.cmd) report_mismatch($sformatf("cmd %0d want %0d", got.cmd, want.cmd));
				if (got.start_cell !== want.start_cell)
					report_mismatch($sformatf("start_cell %0d want %0d", got.start_cell, want.start_cell));
				if (got.end_cell !== want.end_cell)
					report_mismatch($sformatf("end_cell %0d want %0d", got.end_cell, want.end_cell));
				if (got.glyph !== want.glyph)
					report_mismatch($sformatf("glyph %h want %h", got.glyph, want.glyph));
				if (got.attr !== want.attr)
					report_mismatch($sformatf("attr %h want %h", got.attr, want.attr));
				if (got.scroll_lines !== want.scroll_lines)
					report_mismatch($sformatf("scroll_lines %0d want %0d", got.scroll_lines,
						want.scroll_lines));
				if (got.cur_col !== want.cur_col)
					report_mismatch($sformatf("cur_col %0d want %0d", got.cur_col, want.cur_col));
				if (got.cur_row !== want.cur_row)
					report_mismatch($sformatf("cur_row %0d want %0d", got.cur_row, want.cur_row));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
			end
		end
	end

	// Directed: printing, wrap at the right edge, and line feeds scrolling at the bottom.
	task automatic test_print_and_wrap();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("\033[1;79H");
		send_text("xyz");
		send_byte(CH_LF);
		send_text("\033[24d");
		send_byte(CH_LF);
		send_byte(CH_LF);
	endtask

	// Directed: every CSI final but d, saturating arguments, over-long lists and dropped escapes.
	task automatic test_csi_finals();
		send_text("\033[5A\033[3B\033[99C\033[2D\033[E\033[F\033[40G\033[12;34f");
		send_text("\033[s\033[H\033[u\033[0J\033[1J\033[2J\033[0K\033[1K\033[2K\033[7J");
		send_text("\033[S\033[0T\033[999999S\033[1;31;44;22;39;49;0m\033[1;37;47m\033[z");
		send_text("\033[;;;;;;;;;;;;;;;;Q\033Xq\033c");
	endtask

	function automatic logic [7:0] pick_final();
		case ($urandom_range(0, 19))
			0: return CH_A;   1: return CH_B;   2: return CH_C;   3: return CH_D;
			4: return CH_E;   5: return CH_F;   6: return CH_G;   7: return CH_H;
			8: return CH_J;   9: return CH_K;  10: return CH_S;  11: return CH_T;
			12: return CH_LC_D; 13: return CH_LC_F; 14: return CH_LC_M; 15: return CH_LC_S;
			16: return CH_LC_U; 17: return CH_LC_M;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random: mostly well-formed control sequences with random arguments,
	// mixed with plain text, line feeds, resets and raw noise.
	task automatic test_random_stream(input int n_items);
		int sent, nargs, kind;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				send_byte(CH_ESC);
				send_byte(CH_LBR);
				sent += 2;
				nargs = $urandom_range(0, 4);
				for (int a = 0; a < nargs; a++) begin
					case ($urandom_range(0, 3))
						0: send_text($sformatf("%0d", $urandom_range(0, 9)));
						1: send_text($sformatf("%0d", $urandom_range(0, 50)));
						2: send_text($sformatf("%0d", $urandom_range(0, 99999)));
						default: ;
					endcase
					if (a < nargs - 1) send_byte(CH_SEMI);
					sent += 2;
				end
				send_byte(pick_final());
				sent++;
			end else if (kind < 8) begin
				repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(32, 126)));
				sent += 15;
			end else if (kind == 8) begin
				send_byte(($urandom_range(0, 3) == 0) ? CH_ESC : CH_LF);
				if ($urandom_range(0, 5) == 0) send_byte(CH_LC_C);
				sent += 2;
			end else begin
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		sender_idle_on = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		term_mode = MODE_NORMAL;
		for (int i = 0; i < NARGS; i++) begin
			arg_val[i] = '0;
			arg_set[i] = 1'b0;
		end
		arg_idx = 0;
		col = 0; row = 0; save_col = 0; save_row = 0;
		cur_attr = ATTR_RESET;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_print_and_wrap();
		test_csi_finals();
		sender_idle_on = 1'b1;
		test_random_stream(220);
		sender_idle_on = 1'b0;
		test_random_stream(100);
		sender_idle_on = 1'b1;
		test_random_stream(70);
		in_ch.valid <= 1'b0;

		while (pending_ops.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hdl/atte_pkg.sv
hdl/atte_if.sv
hdl/atte_ctrl.sv
hdl/atte_dp.sv
hdl/ansi_text_terminal_engine.sv
verif/atte_tb_if.sv
verif/tb_ansi_text_terminal_engine.sv
